/* rtl/rhh_pkg.sv */
// ----------------------------------------------------------------------------
// rhh_pkg
// Types and constants shared by the robin hood hash table and its hash unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rhh_pkg;

    localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
    // prime is 2^40 + 0x1b3
    localparam int          FNV_SHIFT    = 40;
    localparam logic [63:0] FNV_PRIME_LO = 64'h1b3;

    localparam int DIB_W  = 16;
    localparam int KLEN_W = 4;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [63:0]       key;
        logic [63:0]       value;
        logic [31:0]       vsize;
        logic [DIB_W-1:0]  dib;
        logic [KLEN_W-1:0] klen;
        logic              tomb;
    } t_slot_data;

endpackage

`default_nettype wire

/* rtl/rhh_fnv.sv */
// ----------------------------------------------------------------------------
// rhh_fnv
// Iterative 64-bit FNV-1a hash, one key byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rhh_fnv (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_key,
    input  wire logic [3:0]  i_len,
    output logic             o_done,
    output logic [63:0]      o_hash
);
    import rhh_pkg::*;

    logic        r_busy;
    logic [3:0]  r_cnt;
    logic [63:0] r_shift;
    logic [63:0] r_hash;
    logic [63:0] x;

    assign x      = r_hash ^ {56'd0, r_shift[7:0]};
    assign o_done = r_busy && (r_cnt == 4'd0);
    assign o_hash = r_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hash  <= FNV_BASIS;
            r_shift <= i_key;
            r_cnt   <= i_len;
        end else if (r_busy && r_cnt != 4'd0) begin
            r_hash  <= (x << FNV_SHIFT) + 64'(x * FNV_PRIME_LO);
            r_shift <= r_shift >> 8;
            r_cnt   <= r_cnt - 4'd1;
        end
    end

endmodule

`default_nettype wire

/* rtl/robin_hood_hash_table.sv */
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// Robin hood open-addressing key-value table with insert, lookup and delete.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  in      | i_in_valid / o_in_stall     | operation, key, key length, value, value length
//  out     | o_out_valid / i_out_stall   | status, found value, found length, entry count
//  cfg     | psel penable pwrite pready  | table_size_log2 at address 0
//
//  key_length is clamped to KEY_BYTES. the key is hashed a byte at a time in
//  the fnv unit, then each slot visited gets a read step and a check step on
//  the single-port slot memory. one item is in flight at a time.
//  after reset the hash store is swept to empty, stall held.
//  a finished result moves to an output register, so the next item can start
//  while it waits; a second finished item holds the core and stalls the input.
`default_nettype none

module robin_hood_hash_table #(
    parameter int SLOTS     = 1024,
    parameter int KEY_BYTES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [63:0] i_key_bytes,
    input  wire logic [3:0]  i_key_length,
    input  wire logic [63:0] i_value,
    input  wire logic [31:0] i_value_length,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [63:0]      o_found_value,
    output logic [31:0]      o_found_length,
    output logic [10:0]      o_entry_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rhh_pkg::*;

    localparam int LOG = $clog2(SLOTS + 1) - 1;
    localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SZW = LOG + 1;
    localparam int LVW = $clog2(SLOTS + 1);

    logic [63:0]      hash_mem [SLOTS];
    t_slot_data       data_mem [SLOTS];

    t_state           r_state, n_state;
    logic [IW-1:0]    r_clr, n_clr;
    logic [1:0]       r_op, n_op;
    logic [63:0]      r_ch, n_ch;
    logic [63:0]      r_ck, n_ck;
    logic [63:0]      r_cv, n_cv;
    logic [31:0]      r_cvs, n_cvs;
    logic [DIB_W-1:0] r_cdib, n_cdib;
    logic [3:0]       r_cklen, n_cklen;
    logic             r_swapped, n_swapped;
    logic [IW-1:0]    r_pos, n_pos;
    logic [SZW-1:0]   r_step, n_step;
    logic [LVW-1:0]   r_live, n_live;
    logic [SZW-1:0]   r_used [1:LOG];
    logic             used_inc, used_dec;
    logic [1:0]       r_status, n_status;
    logic [63:0]      r_fval, n_fval;
    logic [31:0]      r_flen, n_flen;
    logic [3:0]       r_tsl;
    logic [63:0]      r_rd_hash;
    t_slot_data       r_rd_data;

    logic             out_load;
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [63:0]      r_out_fval;
    logic [31:0]      r_out_flen;
    logic [10:0]      r_out_count;

    logic             hash_we, data_we;
    logic [63:0]      hash_wd;
    t_slot_data       data_wd;
    logic [IW-1:0]    mem_addr;

    logic             fnv_start, fnv_done;
    logic [63:0]      fnv_hash, fixed_hash;
    logic [3:0]       klen_c;
    logic [63:0]      key_m;

    logic [4:0]       lvl, eff;
    logic [SZW-1:0]   size;
    logic [IW-1:0]    mask;
    logic             has_free, last_step, empty, match, cfg_we;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {28'd0, r_tsl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsl <= 4'd10;
        end else if (cfg_we) begin
            r_tsl <= pwdata[3:0];
        end
    end

    // effective table size
    assign lvl  = (r_tsl == 4'd0) ? 5'd1 : {1'b0, r_tsl};
    assign eff  = (lvl > 5'(LOG)) ? 5'(LOG) : lvl;
    assign size = SZW'(1) << eff;
    assign mask = IW'(size - SZW'(1));

    always_comb begin
        has_free = 1'b0;
        for (int j = 1; j <= LOG; j++) begin
            if (5'(j) == eff) begin
                has_free = r_used[j] < size;
            end
        end
    end

    // key clamp and byte masking
    assign klen_c = (i_key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : i_key_length;
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            key_m[8*b +: 8] = (4'(b) < klen_c) ? i_key_bytes[8*b +: 8] : 8'd0;
        end
    end

    rhh_fnv u_fnv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fnv_start),
        .i_key   (key_m),
        .i_len   (klen_c),
        .o_done  (fnv_done),
        .o_hash  (fnv_hash)
    );

    // hash zero marks an empty slot
    assign fixed_hash = (fnv_hash == 64'd0) ? 64'd1 : fnv_hash;

    assign empty     = (r_rd_hash == 64'd0) || r_rd_data.tomb;
    assign match     = (r_rd_hash == r_ch) && (r_rd_data.klen == r_cklen)
                       && (r_rd_data.key == r_ck);
    assign last_step = (r_step + SZW'(1)) == size;
    assign mem_addr  = (r_state == S_CLEAR) ? r_clr : r_pos;

    // slot memories
    always_ff @(posedge i_clk) begin
        if (hash_we) begin
            hash_mem[mem_addr] <= hash_wd;
        end
        r_rd_hash <= hash_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            data_mem[mem_addr] <= data_wd;
        end
        r_rd_data <= data_mem[mem_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_op      = r_op;
        n_ch      = r_ch;
        n_ck      = r_ck;
        n_cv      = r_cv;
        n_cvs     = r_cvs;
        n_cdib    = r_cdib;
        n_cklen   = r_cklen;
        n_swapped = r_swapped;
        n_pos     = r_pos;
        n_step    = r_step;
        n_live    = r_live;
        n_status  = r_status;
        n_fval    = r_fval;
        n_flen    = r_flen;
        hash_we   = 1'b0;
        data_we   = 1'b0;
        hash_wd   = r_ch;
        data_wd   = '{key: r_ck, value: r_cv, vsize: r_cvs, dib: r_cdib,
                      klen: r_cklen, tomb: 1'b0};
        used_inc  = 1'b0;
        used_dec  = 1'b0;
        fnv_start = 1'b0;
        out_load  = 1'b0;
        o_in_stall  = 1'b1;

        unique case (r_state)
            S_CLEAR: begin
                hash_we = 1'b1;
                hash_wd = 64'd0;
                n_clr   = r_clr + IW'(1);
                if (r_clr == IW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_op      = i_operation;
                    n_ck      = key_m;
                    n_cklen   = klen_c;
                    n_cv      = i_value;
                    n_cvs     = i_value_length;
                    n_cdib    = '0;
                    n_swapped = 1'b0;
                    n_step    = '0;
                    n_fval    = 64'd0;
                    n_flen    = 32'd0;
                    fnv_start = 1'b1;
                    n_state   = S_HASH;
                end
            end
            S_HASH: begin
                if (fnv_done) begin
                    n_ch  = fixed_hash;
                    n_pos = fixed_hash[IW-1:0] & mask;
                    priority if (r_op == OP_INSERT) begin
                        n_status = ST_FULL;
                        n_state  = S_READ;
                    end else if (r_op == OP_LOOKUP || r_op == OP_DELETE) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_READ;
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_READ;
                n_pos   = (r_pos + IW'(1)) & mask;
                n_step  = r_step + SZW'(1);
                if (r_op == OP_INSERT) begin
                    n_cdib = r_cdib + DIB_W'(1);
                    priority if (empty) begin
                        hash_we  = 1'b1;
                        data_we  = 1'b1;
                        used_inc = 1'b1;
                        if (r_live < LVW'(SLOTS)) begin
                            n_live = r_live + LVW'(1);
                        end
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else if (!r_swapped && match) begin
                        data_we       = 1'b1;
                        data_wd       = r_rd_data;
                        data_wd.value = r_cv;
                        data_wd.vsize = r_cvs;
                        n_status      = ST_OK;
                        n_state       = S_DONE;
                    end else if (r_rd_data.dib < r_cdib && !has_free) begin
                        n_state = S_DONE;
                    end else begin
                        if (r_rd_data.dib < r_cdib) begin
                            // take the slot, carry the resident onward
                            hash_we   = 1'b1;
                            data_we   = 1'b1;
                            n_ch      = r_rd_hash;
                            n_ck      = r_rd_data.key;
                            n_cv      = r_rd_data.value;
                            n_cvs     = r_rd_data.vsize;
                            n_cklen   = r_rd_data.klen;
                            n_cdib    = r_rd_data.dib + DIB_W'(1);
                            n_swapped = 1'b1;
                        end
                        if (last_step) begin
                            n_state = S_DONE;
                        end
                    end
                end else begin
                    priority if (r_rd_hash == 64'd0
                                 || DIB_W'(r_step) > r_rd_data.dib) begin
                        n_state = S_DONE;
                    end else if (!r_rd_data.tomb && match) begin
                        n_status = ST_OK;
                        n_state  = S_DONE;
                        if (r_op == OP_LOOKUP) begin
                            n_fval = r_rd_data.value;
                            n_flen = r_rd_data.vsize;
                        end else begin
                            data_we      = 1'b1;
                            data_wd      = r_rd_data;
                            data_wd.tomb = 1'b1;
                            used_dec     = 1'b1;
                            if (r_live != '0) begin
                                n_live = r_live - LVW'(1);
                            end
                        end
                    end else if (last_step) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // hand the result over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_live <= '0;
            for (int j = 1; j <= LOG; j++) begin
                r_used[j] <= '0;
            end
        end else begin
            r_clr  <= n_clr;
            r_live <= n_live;
            // occupied counts for every power-of-two prefix of the table
            for (int j = 1; j <= LOG; j++) begin
                if ((r_pos >> j) == '0) begin
                    if (used_inc) begin
                        r_used[j] <= r_used[j] + SZW'(1);
                    end else if (used_dec) begin
                        r_used[j] <= r_used[j] - SZW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_ch      <= n_ch;
        r_ck      <= n_ck;
        r_cv      <= n_cv;
        r_cvs     <= n_cvs;
        r_cdib    <= n_cdib;
        r_cklen   <= n_cklen;
        r_swapped <= n_swapped;
        r_pos     <= n_pos;
        r_step    <= n_step;
        r_status  <= n_status;
        r_fval    <= n_fval;
        r_flen    <= n_flen;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            r_out_fval   <= r_fval;
            r_out_flen   <= r_flen;
            r_out_count  <= 11'(r_live);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_found_value  = r_out_fval;
    assign o_found_length = r_out_flen;
    assign o_entry_count  = r_out_count;

endmodule

`default_nettype wire
